[src/tvsq_pkg.sv]
package tvsq_pkg;

   // request item fields
   localparam int unsigned VERTEX_BITS    = 6;
   localparam int unsigned VALUE_BITS     = 16;
   localparam int unsigned THRESHOLD_BITS = 18;
   localparam int unsigned COUNT_BITS     = 7;
   localparam int unsigned SET_BITS       = 64;

   // req_tdata layout, lowest bit up
   localparam int unsigned FIRST_LSB     = 0;
   localparam int unsigned SECOND_LSB    = FIRST_LSB + VERTEX_BITS;
   localparam int unsigned VALUE_LSB     = SECOND_LSB + VERTEX_BITS;
   localparam int unsigned THRESHOLD_LSB = VALUE_LSB + VALUE_BITS;
   localparam int unsigned REQ_DATA_BITS = 48;

   localparam logic [COUNT_BITS-1:0] COUNT_RESET = 7'd64;

   typedef enum logic [1:0] {
      ACT_WRITE_LAUNCH = 2'd0,
      ACT_WRITE_REJOIN = 2'd1,
      ACT_ARC_QUERY    = 2'd2,
      ACT_LEG_QUERY    = 2'd3
   } action_type;

   // controller -> datapath
   typedef struct packed {
      logic write_launch;
      logic write_rejoin;
      logic load;
      logic leg_mode;
      logic issue;
      logic publish;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic last_issue;
      logic count_zero;
      logic out_free;
   } status_type;

endpackage

[src/tvsq_ctrl.sv]
module tvsq_ctrl
   import tvsq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  action_type req_action,
   output logic       req_ready,
   input  status_type sts,
   output cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE    = 4'b0001,
      S_SCAN    = 4'b0010,
      S_FLUSH   = 4'b0100,
      S_PUBLISH = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (req_action)
                  ACT_WRITE_LAUNCH: cmd.write_launch = 1'b1;
                  ACT_WRITE_REJOIN: cmd.write_rejoin = 1'b1;
                  ACT_ARC_QUERY, ACT_LEG_QUERY: begin
                     cmd.load     = 1'b1;
                     cmd.leg_mode = (req_action == ACT_LEG_QUERY);
                     state_in     = sts.count_zero ? S_PUBLISH : S_SCAN;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_SCAN: begin
            cmd.issue = 1'b1;
            if (sts.last_issue) begin
               state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            state_in = S_PUBLISH;   // last compare lands in the mask here
         end
         S_PUBLISH: begin
            if (sts.out_free) begin
               cmd.publish = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

[src/tvsq_datapath.sv]
module tvsq_datapath
   import tvsq_pkg::*;
#(
   parameter int unsigned MAX_VERTICES = 64,
   parameter int unsigned TIME_WIDTH   = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  cmd_type                          cmd,
   output status_type                       sts,
   input  logic [VERTEX_BITS-1:0]           first_vertex,
   input  logic [VERTEX_BITS-1:0]           second_vertex,
   input  logic [VALUE_BITS-1:0]            time_value,
   input  logic signed [THRESHOLD_BITS-1:0] threshold,
   input  logic                             csr_write,
   input  logic [COUNT_BITS-1:0]            csr_value,
   input  logic                             out_take,
   output logic                             out_valid,
   output logic [SET_BITS-1:0]              out_set
);

   localparam int unsigned VW    = $clog2(MAX_VERTICES);
   localparam int unsigned NW    = $clog2(MAX_VERTICES + 1);
   localparam int unsigned AW    = 2 * VW;
   localparam int unsigned DEPTH = 1 << AW;
   localparam int unsigned CW    = (TIME_WIDTH + 2 > THRESHOLD_BITS) ?
                                   TIME_WIDTH + 2 : THRESHOLD_BITS;
   localparam logic [COUNT_BITS-1:0]  MAX_COUNT = COUNT_BITS'(MAX_VERTICES);
   localparam logic [VERTEX_BITS:0]   MAX_INDEX = (VERTEX_BITS + 1)'(MAX_VERTICES);

   // tables, row-major {row, column}
   logic [TIME_WIDTH-1:0] launch_mem [DEPTH];
   logic [TIME_WIDTH-1:0] rejoin_mem [DEPTH];

   logic [COUNT_BITS-1:0]            count_ff, count_in;
   logic [VW-1:0]                    a_ff, b_ff;
   logic                             a_ok_ff, b_ok_ff, leg_ff;
   logic signed [THRESHOLD_BITS-1:0] thr_ff;
   logic [VW-1:0]                    z_ff, z_in;
   logic [VW-1:0]                    z1_ff;
   logic                             s1_ff, s1_in;
   logic [TIME_WIDTH-1:0]            rd_a_ff, rd_b_ff, rd_r_ff;
   logic [MAX_VERTICES-1:0]          mask_ff, mask_in;
   logic                             out_valid_ff, out_valid_in;
   logic [SET_BITS-1:0]              out_set_ff;

   logic [COUNT_BITS-1:0]   count_eff;
   logic [NW-1:0]           n_eff;
   logic                    row_ok, col_ok;
   logic [AW-1:0]           wr_addr;
   logic [TIME_WIDTH-1:0]   wr_value;
   logic [TIME_WIDTH-1:0]   la, lb, rj;
   logic signed [CW-1:0]    t_val, thr_val;
   logic                    hit;

   // a count above the table size scans the whole table
   assign count_eff = (count_ff > MAX_COUNT) ? MAX_COUNT : count_ff;
   assign n_eff     = NW'(count_eff);

   assign row_ok   = {1'b0, first_vertex} < MAX_INDEX;
   assign col_ok   = {1'b0, second_vertex} < MAX_INDEX;
   assign wr_addr  = {first_vertex[VW-1:0], second_vertex[VW-1:0]};
   assign wr_value = TIME_WIDTH'(time_value);

   assign sts.last_issue = (NW'(z_ff) + NW'(1)) == n_eff;
   assign sts.count_zero = (n_eff == '0);
   assign sts.out_free   = !out_valid_ff || out_take;

   always_ff @(posedge clock) begin
      if (cmd.write_launch && row_ok && col_ok) begin
         launch_mem[wr_addr] <= wr_value;
      end
      if (cmd.write_rejoin && row_ok && col_ok) begin
         rejoin_mem[wr_addr] <= wr_value;
      end
      if (cmd.issue) begin
         rd_a_ff <= launch_mem[{a_ff, z_ff}];
         rd_b_ff <= launch_mem[{b_ff, z_ff}];
         rd_r_ff <= rejoin_mem[{z_ff, b_ff}];
      end
   end

   // out-of-range query vertices read as zero
   assign la = a_ok_ff ? rd_a_ff : '0;
   assign lb = b_ok_ff ? rd_b_ff : '0;
   assign rj = b_ok_ff ? rd_r_ff : '0;

   always_comb begin
      if (leg_ff) begin
         t_val = CW'(la) + CW'(rj);
      end else begin
         t_val = CW'(la) - CW'(lb);
      end
      thr_val = CW'(thr_ff);
      hit     = t_val > thr_val;   // strict: ties stay out
   end

   always_comb begin
      count_in     = csr_write ? csr_value : count_ff;
      z_in         = cmd.load ? '0 : (cmd.issue ? z_ff + VW'(1) : z_ff);
      s1_in        = cmd.issue;
      mask_in      = mask_ff;
      if (cmd.load) begin
         mask_in = '0;
      end else if (s1_ff) begin
         mask_in[z1_ff] = hit;
      end
      out_valid_in = out_valid_ff;
      if (cmd.publish) begin
         out_valid_in = 1'b1;
      end else if (out_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= COUNT_RESET;
         s1_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         s1_ff        <= s1_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         a_ff    <= first_vertex[VW-1:0];
         b_ff    <= second_vertex[VW-1:0];
         a_ok_ff <= row_ok;
         b_ok_ff <= col_ok;
         leg_ff  <= cmd.leg_mode;
         thr_ff  <= threshold;
      end
      z_ff    <= z_in;
      z1_ff   <= z_ff;
      mask_ff <= mask_in;
      if (cmd.publish) begin
         out_set_ff <= SET_BITS'(mask_ff);
      end
   end

   assign out_valid = out_valid_ff;
   assign out_set   = out_set_ff;

endmodule

[src/threshold_vertex_set_query.sv]
// Threshold vertex-set query. Holds two MAX_VERTICES x MAX_VERTICES tables
// of TIME_WIDTH-bit travel times (launch and rejoin), loaded one entry per
// write item, and answers queries with a 64-bit vertex mask: bit z is set
// when the derived time of vertex z is strictly above the signed threshold
// (arc: launch[a][z] - launch[b][z]; leg: launch[a][z] + rejoin[z][b]).
// A write item produces no result and leaves the block ready for the next
// item. A query scans the first min(active count, MAX_VERTICES) vertices one
// per cycle and occupies the block through accept, scan, pipeline flush and
// publish; with a zero count it goes from accept straight to publish. The
// publish also waits for a stalled result to be taken. The scan rate is set
// by the single table read per vertex on the launch memory's two read ports
// and the rejoin memory's one. Results sit in an output register, so new
// items are accepted while a result waits.
// Table entries power up undefined; a query must only touch written entries.
// The active vertex count register (reset 64) is written through the csr
// channel while the block is idle, a rule for the user that the block does not enforce.
module threshold_vertex_set_query
   import tvsq_pkg::*;
#(
   parameter int unsigned MAX_VERTICES = 64,
   parameter int unsigned TIME_WIDTH   = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   // request items
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,  // first_vertex[5:0], second_vertex[11:6],
                                                // time_value[27:12], threshold[45:28],
                                                // zero pad[47:46]
   input  logic [1:0]               req_tuser,  // action[1:0]
   // result items
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [SET_BITS-1:0]      rsp_tdata,  // member_set[63:0]
   // active vertex count register
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [COUNT_BITS-1:0]    csr_data
);

   cmd_type    cmd;
   status_type sts;
   action_type action;

   assign action    = action_type'(req_tuser);
   assign csr_ready = 1'b1;   // register write is always accepted

   tvsq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_action (action),
      .req_ready  (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   tvsq_datapath #(
      .MAX_VERTICES (MAX_VERTICES),
      .TIME_WIDTH   (TIME_WIDTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .first_vertex  (req_tdata[FIRST_LSB +: VERTEX_BITS]),
      .second_vertex (req_tdata[SECOND_LSB +: VERTEX_BITS]),
      .time_value    (req_tdata[VALUE_LSB +: VALUE_BITS]),
      .threshold     (signed'(req_tdata[THRESHOLD_LSB +: THRESHOLD_BITS])),
      .csr_write     (csr_valid && csr_ready),
      .csr_value     (csr_data),
      .out_take      (rsp_tready),
      .out_valid     (rsp_tvalid),
      .out_set       (rsp_tdata)
   );

endmodule

[src/tvsq_checker.sv]
module tvsq_checker
   import tvsq_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_tvalid,
   input logic                     req_tready,
   input logic [1:0]               req_tuser,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [SET_BITS-1:0]      rsp_tdata
);

   logic req_acc;
   assign req_acc = req_tvalid && req_tready;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // a table write never blocks the next item
   a_write_ready: assert property (@(posedge clock) disable iff (reset)
      req_acc && (req_tuser == ACT_WRITE_LAUNCH || req_tuser == ACT_WRITE_REJOIN)
      |=> req_tready)
      else $error("ready dropped after a write");

   // a query holds off further items while it scans
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_acc && (req_tuser == ACT_ARC_QUERY || req_tuser == ACT_LEG_QUERY)
      |=> !req_tready)
      else $error("item accepted during a scan");

   // a new result is published only as a query ends
   a_publish_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> req_tready && !$past(req_tready))
      else $error("result appeared outside a query end");

endmodule

bind threshold_vertex_set_query tvsq_checker u_tvsq_checker (.*);
